// ===== rtl/core/srpsd_pkg.sv =====
// Shared types and constants for the speed-reached and position-step detector.
// Holds the register map, reset values and field widths.
// Depends on nothing.
`default_nettype none

package srpsd_pkg;

	// field widths
	localparam int VelW      = 32;
	localparam int PosW      = 32;
	localparam int TolW      = 16;
	localparam int SettleW   = 8;
	localparam int GainW     = 16;
	localparam int ScaleW    = 32;
	localparam int FracW     = 16;
	localparam int FiltW     = VelW + FracW;
	localparam int CfgDataW  = 32;
	localparam int InDataW   = 96;
	localparam int OutDataW  = 40;

	// register map
	typedef enum logic [1:0] {
		REG_VEL_TOL    = 2'd0,
		REG_SETTLE_CNT = 2'd1,
		REG_FILT_GAIN  = 2'd2,
		REG_POS_SCALE  = 2'd3
	} reg_idx_t;

	// reset values
	localparam logic [TolW-1:0]    VelTolRst    = 16'd970;
	localparam logic [SettleW-1:0] SettleCntRst = 8'd10;
	localparam logic [GainW-1:0]   FiltGainRst  = 16'd328;
	localparam logic [ScaleW-1:0]  PosScaleRst  = 32'd17713938;

	typedef struct packed {
		logic [TolW-1:0]    velocity_tolerance;
		logic [SettleW-1:0] settle_count;
		logic [GainW-1:0]   filter_gain;
		logic [ScaleW-1:0]  position_scale;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/srpsd_speed_unit.sv =====
// Velocity low-pass filter, speed window test and settle counter.
// Holds the filter value and settle counter; state advances when en is high.
// Depends on srpsd_pkg.
`default_nettype none

module srpsd_speed_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire srpsd_pkg::cfg_t                   cfg,
	input  wire logic signed [srpsd_pkg::VelW-1:0] target_velocity,
	input  wire logic signed [srpsd_pkg::VelW-1:0] actual_velocity,
	output logic                                   speed_reached,
	output logic signed [srpsd_pkg::VelW-1:0]      filtered_velocity
);

	logic [srpsd_pkg::FiltW-1:0]    filt_q;
	logic [srpsd_pkg::SettleW-1:0]  settle_cnt_q;

	logic [srpsd_pkg::FiltW-1:0]    x;
	logic [srpsd_pkg::FiltW:0]      diff;
	logic [srpsd_pkg::FiltW:0]      diff_abs;
	logic [63:0]                    prod;
	logic [srpsd_pkg::FiltW-1:0]    step;
	logic [srpsd_pkg::FiltW-1:0]    filt_next;
	logic [srpsd_pkg::FiltW-1:0]    filt_abs;
	logic [srpsd_pkg::VelW-1:0]     mag;
	logic [33:0]                    win_lo;
	logic [33:0]                    win_hi;
	logic [33:0]                    mag_ext;
	logic                           in_win;
	logic                           tgt_nz;
	logic                           settled;
	logic [srpsd_pkg::SettleW-1:0]  settle_cnt_next;

	// filter step: y += sign(x-y) * ((|x-y| * gain) >> 16)
	always_comb begin
		x        = {actual_velocity, {srpsd_pkg::FracW{1'b0}}};
		diff     = {x[srpsd_pkg::FiltW-1], x} - {filt_q[srpsd_pkg::FiltW-1], filt_q};
		diff_abs = diff[srpsd_pkg::FiltW] ? ((srpsd_pkg::FiltW+1)'(0) - diff) : diff;
		prod     = {16'b0, diff_abs[srpsd_pkg::FiltW-1:0]} * {48'b0, cfg.filter_gain};
		step     = prod[63:16];
		filt_next = diff[srpsd_pkg::FiltW] ? (filt_q - step) : (filt_q + step);
	end

	// integer magnitude, truncated toward zero
	always_comb begin
		filt_abs = filt_next[srpsd_pkg::FiltW-1] ?
			(srpsd_pkg::FiltW'(0) - filt_next) : filt_next;
		mag = filt_abs[srpsd_pkg::FiltW-1:srpsd_pkg::FracW];
		filtered_velocity = filt_next[srpsd_pkg::FiltW-1] ?
			(srpsd_pkg::VelW'(0) - mag) : mag;
	end

	// speed window and settle counter
	always_comb begin
		win_lo  = {{2{target_velocity[31]}}, target_velocity} - {18'b0, cfg.velocity_tolerance};
		win_hi  = {{2{target_velocity[31]}}, target_velocity} + {18'b0, cfg.velocity_tolerance};
		mag_ext = {2'b0, mag};
		in_win  = ($signed(win_lo) <= $signed(mag_ext)) && ($signed(win_hi) >= $signed(mag_ext));
		tgt_nz  = target_velocity != '0;
		settled = settle_cnt_q >= cfg.settle_count;
		speed_reached = tgt_nz && in_win && settled;
		if (!tgt_nz) begin
			settle_cnt_next = settle_cnt_q;
		end else if (!in_win) begin
			settle_cnt_next = '0;
		end else if (settled) begin
			settle_cnt_next = settle_cnt_q;
		end else begin
			settle_cnt_next = settle_cnt_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q       <= '0;
			settle_cnt_q <= '0;
		end else if (en) begin
			filt_q       <= filt_next;
			settle_cnt_q <= settle_cnt_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/srpsd_pos_unit.sv =====
// Position scaling by a Q32 factor and step pulse on a change of the count.
// Holds the last scaled count; it advances when en is high.
// Depends on srpsd_pkg.
`default_nettype none

module srpsd_pos_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic [srpsd_pkg::ScaleW-1:0]      position_scale,
	input  wire logic signed [srpsd_pkg::PosW-1:0] actual_position,
	output logic                                   position_step
);

	logic [srpsd_pkg::PosW-1:0] count_q;
	logic [srpsd_pkg::PosW-1:0] pos_abs;
	logic [63:0]                prod;
	logic [srpsd_pkg::PosW-1:0] scaled_abs;
	logic [srpsd_pkg::PosW-1:0] count_next;

	// |pos| * scale >> 32, sign restored: truncation toward zero
	always_comb begin
		pos_abs    = actual_position[31] ? (32'd0 - actual_position) : actual_position;
		prod       = {32'b0, pos_abs} * {32'b0, position_scale};
		scaled_abs = prod[63:32];
		count_next = actual_position[31] ? (32'd0 - scaled_abs) : scaled_abs;
		position_step = count_next != count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= count_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/speed_reached_and_position_step_detector.sv =====
// Top level of the speed-reached and position-step detector.
// Input register, speed and position units, output register, config registers.
// Depends on srpsd_pkg, srpsd_speed_unit and srpsd_pos_unit.
//
// Usage:
//   s_axis carries one tick: target velocity, actual velocity, actual position.
//   m_axis returns one word per tick: speed_reached, position_step and the
//   integer part of the filtered velocity.
//   m_axis_tvalid rises once the tick has passed the input register, then the
//   result register; while m_axis_tready is high one word is taken every cycle.
//   The filter recurrence (subtract, 48x16 multiply, add) is combinational
//   around filt_q, so it sets the cycle time with the 32x32 position multiply.
//   The cfg port writes a register whenever cfg_wr_en is high; write only while
//   no tick is in flight.
//   Reset clears the filter, settle counter and scaled position count, empties
//   both stages and loads the register defaults.
//   When m_axis_tready is low the result word holds; one more tick is taken
//   into an empty input register, then s_axis_tready drops until output drains.
`default_nettype none

module speed_reached_and_position_step_detector (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// config write port
	input  wire logic                                 cfg_wr_en,
	input  wire logic [1:0]                           cfg_index,
	input  wire logic [srpsd_pkg::CfgDataW-1:0]       cfg_data,
	// input stream
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// [31:0] target_velocity, [63:32] actual_velocity, [95:64] actual_position
	input  wire logic [srpsd_pkg::InDataW-1:0]        s_axis_tdata,
	// output stream
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// [0] speed_reached, [1] position_step, [33:2] filtered_velocity, [39:34] zero
	output logic [srpsd_pkg::OutDataW-1:0]            m_axis_tdata
);

	srpsd_pkg::cfg_t cfg_q;

	logic                                valid_s1;
	logic signed [srpsd_pkg::VelW-1:0]   target_s1;
	logic signed [srpsd_pkg::VelW-1:0]   vel_s1;
	logic signed [srpsd_pkg::PosW-1:0]   pos_s1;

	logic                                valid_s2;
	logic [srpsd_pkg::OutDataW-1:0]      data_s2;

	logic                                adv_s2;
	logic                                adv_s1;
	logic                                speed_reached;
	logic                                position_step;
	logic signed [srpsd_pkg::VelW-1:0]   filtered_velocity;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.velocity_tolerance <= srpsd_pkg::VelTolRst;
			cfg_q.settle_count       <= srpsd_pkg::SettleCntRst;
			cfg_q.filter_gain        <= srpsd_pkg::FiltGainRst;
			cfg_q.position_scale     <= srpsd_pkg::PosScaleRst;
		end else if (cfg_wr_en) begin
			unique case (srpsd_pkg::reg_idx_t'(cfg_index))
				srpsd_pkg::REG_VEL_TOL:    cfg_q.velocity_tolerance <= cfg_data[15:0];
				srpsd_pkg::REG_SETTLE_CNT: cfg_q.settle_count       <= cfg_data[7:0];
				srpsd_pkg::REG_FILT_GAIN:  cfg_q.filter_gain        <= cfg_data[15:0];
				srpsd_pkg::REG_POS_SCALE:  cfg_q.position_scale     <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			target_s1 <= s_axis_tdata[31:0];
			vel_s1    <= s_axis_tdata[63:32];
			pos_s1    <= s_axis_tdata[95:64];
		end
	end

	srpsd_speed_unit u_speed (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (adv_s1),
		.cfg               (cfg_q),
		.target_velocity   (target_s1),
		.actual_velocity   (vel_s1),
		.speed_reached     (speed_reached),
		.filtered_velocity (filtered_velocity)
	);

	srpsd_pos_unit u_pos (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (adv_s1),
		.position_scale  (cfg_q.position_scale),
		.actual_position (pos_s1),
		.position_step   (position_step)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s2 <= {6'b0, filtered_velocity, position_step, speed_reached};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

endmodule

`default_nettype wire
